// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of aclk while aresetn is high.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checks an implication whose consequent starts in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sphs_pkg.sv =====
// Package of types and constants for the space packet header stripper.
`default_nettype none
package sphs_pkg;

    localparam int HEADER_BYTES = 6;

    localparam int POS_W = 17;
    localparam int CNT_W = 16;
    localparam int LEN_W = 16;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_STRIP  = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_OVER_CAP  = 2'd3;

    localparam logic [LEN_W-1:0] MAX_OUT_LEN_RESET = 16'd1024;

    typedef struct packed {
        logic             keep;
        logic             summ;
        logic [7:0]       data;
        logic [LEN_W-1:0] olen;
        logic [1:0]       status;
    } res_t;

endpackage
`default_nettype wire

// ===== rtl/space_packet_header_stripper_unit.sv =====
// The first result of an item is offered in the cycle after the item is accepted.
// Throughput: one byte per cycle while the receiver is ready; a buffer's final byte that is
// kept also yields a summary, so the single result register holds the next byte back.
// Reset: synchronous, active low; clears the per-buffer state and the pending flags of the
// result register, and sets the output capacity to 1024 bytes.
`default_nettype none
module space_packet_header_stripper_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,   // max_out_len
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // data_byte
    input  wire logic        s_tlast,     // buffer_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,     // out_byte, out_length, status, zero fill
    output logic             m_tuser,     // is_summary
    output logic             m_tlast      // last
);
    import sphs_pkg::*;

    logic [LEN_W-1:0] max_out_len_reg;
    logic             accept;
    res_t             res;
    logic [7:0]       out_byte;
    logic [LEN_W-1:0] out_length;
    logic [1:0]       status;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_out_len_reg <= MAX_OUT_LEN_RESET;
        end else if (cfg_we) begin
            max_out_len_reg <= cfg_wdata;
        end
    end

    sphs_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .data_byte   (s_tdata),
        .buffer_end  (s_tlast),
        .max_out_len (max_out_len_reg),
        .res         (res)
    );

    sphs_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept),
        .res        (res),
        .can_accept (s_tready),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_byte     (out_byte),
        .m_summ     (m_tuser),
        .m_olen     (out_length),
        .m_status   (status),
        .m_last     (m_tlast)
    );

    assign m_tdata = {6'd0, status, out_length, out_byte};

endmodule
`default_nettype wire

// ===== rtl/sphs_core.sv =====
// Per-buffer packet tracking state and the result of one accepted item.
`default_nettype none
module sphs_core (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     accept,
    input  wire logic [7:0]               data_byte,
    input  wire logic                     buffer_end,
    input  wire logic [sphs_pkg::LEN_W-1:0] max_out_len,
    output sphs_pkg::res_t                res
);
    import sphs_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] total_reg, total_next;
    logic [7:0]       len_high_reg, len_high_next;
    logic             first_reg, first_next;
    logic [CNT_W-1:0] in_cnt_reg, in_cnt_next;
    logic [CNT_W-1:0] strip_cnt_reg, strip_cnt_next;
    logic             keep;
    logic             wrap;
    logic [LEN_W-1:0] olen;
    logic [1:0]       status;

    always_comb begin
        len_high_next = (pos_reg == POS_W'(HEADER_BYTES - 2)) ? data_byte : len_high_reg;
        if (pos_reg == POS_W'(HEADER_BYTES - 1)) begin
            total_next = POS_W'({len_high_reg, data_byte}) + POS_W'(HEADER_BYTES + 1);
        end else begin
            total_next = total_reg;
        end
        keep = first_reg || (pos_reg >= POS_W'(HEADER_BYTES));
        in_cnt_next = (in_cnt_reg == '1) ? in_cnt_reg : in_cnt_reg + 1'b1;
        strip_cnt_next = (!keep && strip_cnt_reg != '1) ? strip_cnt_reg + 1'b1
                                                        : strip_cnt_reg;
        wrap = (pos_reg >= POS_W'(HEADER_BYTES - 1))
            && ((POS_W + 1)'(pos_reg) + 1'b1 >= (POS_W + 1)'(total_next));
        pos_next   = wrap ? '0 : pos_reg + 1'b1;
        first_next = wrap ? 1'b0 : first_reg;
        olen = (in_cnt_next >= strip_cnt_next) ? in_cnt_next - strip_cnt_next : '0;
        if (pos_next != '0) begin
            status = ST_TRUNCATED;
        end else if (olen > max_out_len) begin
            status = ST_OVER_CAP;
        end else if (strip_cnt_next == '0) begin
            status = ST_NO_STRIP;
        end else begin
            status = ST_OK;
        end
        res.keep   = keep;
        res.summ   = buffer_end;
        res.data   = data_byte;
        res.olen   = olen;
        res.status = status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && buffer_end)) begin
            pos_reg       <= '0;
            total_reg     <= '0;
            len_high_reg  <= '0;
            first_reg     <= 1'b1;
            in_cnt_reg    <= '0;
            strip_cnt_reg <= '0;
        end else if (accept) begin
            pos_reg       <= pos_next;
            total_reg     <= total_next;
            len_high_reg  <= len_high_next;
            first_reg     <= first_next;
            in_cnt_reg    <= in_cnt_next;
            strip_cnt_reg <= strip_cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sphs_out.sv =====
// Result register that holds a data result and a summary and sends them in turn.
`default_nettype none
module sphs_out (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     load,
    input  wire sphs_pkg::res_t           res,
    output logic                          can_accept,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [7:0]                    m_byte,
    output logic                          m_summ,
    output logic [sphs_pkg::LEN_W-1:0]    m_olen,
    output logic [1:0]                    m_status,
    output logic                          m_last
);
    import sphs_pkg::*;

    logic             data_pend_reg, data_pend_next;
    logic             summ_pend_reg, summ_pend_next;
    logic [7:0]       byte_reg;
    logic [LEN_W-1:0] olen_reg;
    logic [1:0]       status_reg;
    logic             fire;

    assign m_valid  = data_pend_reg || summ_pend_reg;
    assign fire     = m_valid && m_ready;
    assign m_byte   = data_pend_reg ? byte_reg : '0;
    assign m_summ   = !data_pend_reg;
    assign m_olen   = data_pend_reg ? '0 : olen_reg;
    assign m_status = data_pend_reg ? ST_OK : status_reg;
    assign m_last   = !data_pend_reg;

    assign can_accept = !m_valid || (fire && !(data_pend_reg && summ_pend_reg));

    always_comb begin
        data_pend_next = data_pend_reg;
        summ_pend_next = summ_pend_reg;
        if (fire) begin
            if (data_pend_reg) begin
                data_pend_next = 1'b0;
            end else begin
                summ_pend_next = 1'b0;
            end
        end
        if (load) begin
            data_pend_next = res.keep;
            summ_pend_next = res.summ;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_pend_reg <= 1'b0;
            summ_pend_reg <= 1'b0;
        end else begin
            data_pend_reg <= data_pend_next;
            summ_pend_reg <= summ_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg   <= res.data;
            olen_reg   <= res.olen;
            status_reg <= res.status;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sphs_checker.sv =====
// Port-level checks for the header stripper and their binding to the top level.
`default_nettype none
`include "assert_macros.svh"
module sphs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);
    logic        data_beat;
    logic        summ_beat;
    logic        data_clean;
    logic        summ_clean;
    logic        end_accept;
    logic        stall;
    logic [33:0] m_word;

    assign data_beat  = m_tvalid && !m_tuser;
    assign summ_beat  = m_tvalid && m_tuser;
    assign data_clean = !m_tlast && (m_tdata[31:8] == 24'd0);
    assign summ_clean = m_tlast && (m_tdata[7:0] == 8'd0);
    assign end_accept = s_tvalid && s_tready && s_tlast;
    assign stall      = m_tvalid && !m_tready;
    assign m_word     = {m_tlast, m_tuser, m_tdata};

    // A data item never closes the buffer and carries no length or status.
    `ASSERT_CLK(a_data_clean, !data_beat || data_clean, "data item with summary fields")
    // A summary item always closes the buffer and carries no byte.
    `ASSERT_CLK(a_summ_last, !summ_beat || summ_clean, "summary item malformed")
    // The final byte of a buffer always leaves a result waiting.
    `ASSERT_NEXT(a_end_result, end_accept, m_tvalid, "no result after buffer end")
    // A stalled result holds.
    `ASSERT_NEXT(a_stall_hold, stall, m_tvalid && $stable(m_word), "stalled result changed")

endmodule

bind space_packet_header_stripper_unit sphs_checker u_sphs_checker (.*);
`default_nettype wire

// ===== test/space_packet_header_stripper_unit_tb.sv =====
// Self-checking testbench that streams packet buffers through the stripper.
`timescale 1ns / 100ps
module space_packet_header_stripper_unit_tb;
    import sphs_pkg::*;

    typedef struct packed {
        logic [7:0]  data;
        logic        summ;
        logic [15:0] olen;
        logic [1:0]  status;
        logic        last;
    } stripped_item_t;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_MOSTLY} rx_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    space_packet_header_stripper_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Copy of the stripper state kept by the testbench.
    logic [16:0] cur_offset;
    logic [16:0] cur_span;
    logic [7:0]  len_msb;
    logic        first_packet;
    logic [15:0] bytes_in;
    logic [15:0] bytes_dropped;
    logic [15:0] out_capacity;

    stripped_item_t expected_out_q[$];

    int errors = 0;
    int items_sent = 0;
    int results_checked = 0;
    int summaries_seen = 0;
    int status_count[4] = '{0, 0, 0, 0};
    int input_stall_cycles = 0;

    int gap_max = 0;
    int burst_left = 1;
    rx_mode_t rx_mode = RX_ALWAYS;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int hold_len = 300;
    int rx_tick = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("space_packet_header_stripper_unit regression: fail");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (errors < 30) begin
            $display("mismatch in %s at result %0d: got %0h, want %0h",
                     what, results_checked, got, want);
        end
        errors++;
    endtask

    task automatic clear_buffer_model();
        cur_offset    = '0;
        cur_span      = '0;
        len_msb       = '0;
        first_packet  = 1'b1;
        bytes_in      = '0;
        bytes_dropped = '0;
    endtask

    task automatic predict_strip(input logic [7:0] b, input logic e);
        int             p;
        logic           keep;
        logic [15:0]    olen;
        stripped_item_t r;
        p = cur_offset;
        if (p == HEADER_BYTES - 2) begin
            len_msb = b;
        end else if (p == HEADER_BYTES - 1) begin
            cur_span = 17'({len_msb, b}) + 17'(HEADER_BYTES + 1);
        end
        keep = first_packet || (p >= HEADER_BYTES);
        if (bytes_in != 16'hFFFF) bytes_in++;
        if (!keep && bytes_dropped != 16'hFFFF) bytes_dropped++;
        if (p >= HEADER_BYTES - 1 && p + 1 >= int'(cur_span)) begin
            cur_offset   = '0;
            first_packet = 1'b0;
        end else begin
            cur_offset = 17'(p + 1);
        end
        if (keep) begin
            r = '{data: b, summ: 1'b0, olen: 16'd0, status: ST_OK, last: 1'b0};
            expected_out_q.push_back(r);
        end
        if (e) begin
            olen = (bytes_in >= bytes_dropped) ? bytes_in - bytes_dropped : 16'd0;
            r = '{data: 8'd0, summ: 1'b1, olen: olen, status: ST_OK, last: 1'b1};
            if (cur_offset != 0) begin
                r.status = ST_TRUNCATED;
            end else if (olen > out_capacity) begin
                r.status = ST_OVER_CAP;
            end else if (bytes_dropped == 0) begin
                r.status = ST_NO_STRIP;
            end
            expected_out_q.push_back(r);
            clear_buffer_model();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic e);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= e;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_strip(b, e);
        items_sent++;
        if (gap_max > 0) begin
            burst_left--;
            if (burst_left <= 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge aclk);
                burst_left = $urandom_range(1, 16);
            end
        end
    endtask

    // Sends the first n_send bytes of a packet whose header carries len.
    task automatic send_packet(input int len, input int n_send, input bit close);
        int          i;
        logic [15:0] l;
        logic [7:0]  b;
        l = 16'(len);
        for (i = 0; i < n_send; i++) begin
            if (i == HEADER_BYTES - 2) begin
                b = l[15:8];
            end else if (i == HEADER_BYTES - 1) begin
                b = l[7:0];
            end else begin
                b = 8'($urandom_range(0, 255));
            end
            send_byte(b, close && (i == n_send - 1));
        end
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (expected_out_q.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_out_q.size() != 0) begin
            report_mismatch("results never delivered", 32'(expected_out_q.size()), 32'd0);
            expected_out_q.delete();
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        out_capacity = value;
    endtask

    task automatic send_random_buffer();
        int kind;
        int npk;
        int len;
        int span;
        int cut;
        int n;
        int i;
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
            npk = $urandom_range(1, 4);
            for (i = 0; i < npk; i++) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 200)
                                                  : $urandom_range(0, 12);
                span = len + HEADER_BYTES + 1;
                if (i == npk - 1) begin
                    cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, span - 1) : span;
                    send_packet(len, cut, 1'b1);
                end else begin
                    send_packet(len, span, 1'b0);
                end
            end
        end else if (kind == 7) begin
            n = $urandom_range(1, 24);
            for (i = 0; i < n; i++) begin
                send_byte(8'($urandom_range(0, 255)), i == n - 1);
            end
        end else if (kind == 8) begin
            len = $urandom_range(0, 12);
            send_packet(len, len + HEADER_BYTES + 1, 1'b0);
            send_packet($urandom_range(0, 65535), $urandom_range(1, 40), 1'b1);
        end else begin
            send_packet($urandom_range(0, 65535), $urandom_range(1, HEADER_BYTES), 1'b1);
        end
    endtask

    // A single byte, two packets after a stray leading byte, and a buffer ending inside a dropped header.
    task automatic test_directed_cases();
        gap_max    = 4;
        burst_left = 1;
        rx_mode    = RX_RANDOM;
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_packet(1, 7, 1'b0);
        send_packet(0, 7, 1'b1);
        send_packet(0, 7, 1'b0);
        send_packet(3, 4, 1'b1);
        drain_results();
    endtask

    task automatic test_capacity_extremes();
        gap_max    = 2;
        burst_left = 1;
        rx_mode    = RX_PATTERN;
        write_capacity(16'd0);
        send_packet(0, 7, 1'b0);
        send_packet(0, 7, 1'b1);
        send_byte(8'h5A, 1'b1);
        drain_results();
        write_capacity(16'd7);
        send_packet(0, 7, 1'b1);
        send_packet(1, 8, 1'b1);
        drain_results();
        write_capacity(16'd1);
        send_packet(0, 7, 1'b0);
        send_packet(2, 9, 1'b1);
        drain_results();
        write_capacity(16'hFFFF);
        send_packet(40, 47, 1'b0);
        send_packet(5, 12, 1'b1);
        drain_results();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering items.
    task automatic test_backpressure();
        write_capacity(MAX_OUT_LEN_RESET);
        gap_max      = 0;
        rx_mode      = RX_ALWAYS;
        hold_request = 1'b1;
        send_packet(20, 27, 1'b0);
        send_packet(10, 17, 1'b0);
        send_packet(30, 37, 1'b1);
        drain_results();
    endtask

    task automatic test_random_buffers();
        logic [15:0] caps[5];
        int          gaps[5];
        rx_mode_t    modes[5];
        int          p;
        int          start;
        caps[0] = 16'd1;
        caps[1] = 16'($urandom_range(8, 60));
        caps[2] = 16'hFFFF;
        caps[3] = 16'($urandom_range(0, 65535));
        caps[4] = 16'($urandom_range(20, 200));
        gaps    = '{0, 3, 8, 1, 5};
        modes   = '{RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_MOSTLY, RX_RANDOM};
        for (p = 0; p < 5; p++) begin
            write_capacity(caps[p]);
            rx_mode    = modes[p];
            gap_max    = gaps[p];
            burst_left = 1;
            start      = items_sent;
            while (items_sent - start < 165) send_random_buffer();
            drain_results();
        end
    endtask

    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            rx_tick++;
            if (hold_request) begin
                hold_left    = hold_len;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS: begin
                        m_tready <= 1'b1;
                    end
                    RX_RANDOM: begin
                        m_tready <= ($urandom_range(0, 9) < 6);
                    end
                    RX_PATTERN: begin
                        m_tready <= ((rx_tick % 7) < 4);
                    end
                    default: begin
                        m_tready <= ($urandom_range(0, 19) != 0);
                    end
                endcase
            end
        end
    end

    always @(posedge aclk) begin : result_check
        stripped_item_t want;
        if (aresetn && s_tvalid && !s_tready) input_stall_cycles++;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_out_q.size() == 0) begin
                report_mismatch("result with none expected", m_tdata, 32'd0);
            end else begin
                want = expected_out_q.pop_front();
                if (m_tdata[7:0] !== want.data) begin
                    report_mismatch("out_byte", 32'(m_tdata[7:0]), 32'(want.data));
                end
                if (m_tuser !== want.summ) begin
                    report_mismatch("is_summary", 32'(m_tuser), 32'(want.summ));
                end
                if (m_tdata[23:8] !== want.olen) begin
                    report_mismatch("out_length", 32'(m_tdata[23:8]), 32'(want.olen));
                end
                if (m_tdata[25:24] !== want.status) begin
                    report_mismatch("status", 32'(m_tdata[25:24]), 32'(want.status));
                end
                if (m_tlast !== want.last) begin
                    report_mismatch("last", 32'(m_tlast), 32'(want.last));
                end
                if (m_tdata[31:26] !== 6'd0) begin
                    report_mismatch("zero fill", 32'(m_tdata[31:26]), 32'd0);
                end
                if (want.summ) begin
                    summaries_seen++;
                    status_count[want.status]++;
                end
            end
            results_checked++;
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 16'd0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'd0;
        s_tlast   = 1'b0;
        out_capacity = MAX_OUT_LEN_RESET;
        clear_buffer_model();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_capacity_extremes();
        test_backpressure();
        test_random_buffers();
        drain_results();
        repeat (20) @(posedge aclk);
        $display("covered %0d input items, %0d results and %0d buffer summaries; input held %0d cycles",
                 items_sent, results_checked, summaries_seen, input_stall_cycles);
        $display("summaries ok %0d, nothing stripped %0d, truncated %0d, over capacity %0d",
                 status_count[ST_OK], status_count[ST_NO_STRIP],
                 status_count[ST_TRUNCATED], status_count[ST_OVER_CAP]);
        if (errors == 0) begin
            $display("space_packet_header_stripper_unit regression: pass");
        end else begin
            $display("space_packet_header_stripper_unit regression: fail");
        end
        $finish;
    end

endmodule
